### src/rbsd_pkg.sv
// Package for the rolling baseline spike detector.
// Shared widths, limits, register indexes and payload types; no dependencies.
package rbsd_pkg;

    localparam int LEVEL_W    = 7;
    localparam int BIN_W      = 8;
    localparam int RATIO_W    = 10;
    localparam int COOL_W     = 12;
    localparam int LVL100_W   = 14;
    localparam int PROD_W     = LEVEL_W + RATIO_W;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 24;
    localparam int QUEUE_DEPTH = 4;

    localparam int LEVEL_MAX_INT = 100;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(LEVEL_MAX_INT);
    localparam logic [LVL100_W-1:0] PERCENT  = LVL100_W'(100);

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_RATIO_PCT       = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MOTION_FLOOR    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_BREATHING_FLOOR = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS      = CFG_IDX_W'(3);

    // reset values and legal ranges of the registers
    localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(250);
    localparam logic [RATIO_W-1:0] RATIO_MIN   = RATIO_W'(110);
    localparam logic [RATIO_W-1:0] RATIO_MAX   = RATIO_W'(1000);
    localparam logic [LEVEL_W-1:0] MOTION_FLOOR_RESET    = LEVEL_W'(60);
    localparam logic [LEVEL_W-1:0] BREATHING_FLOOR_RESET = LEVEL_W'(50);
    localparam logic [LEVEL_W-1:0] FLOOR_MIN   = LEVEL_W'(1);
    localparam logic [LEVEL_W-1:0] FLOOR_MAX   = LEVEL_MAX;
    localparam logic [COOL_W-1:0]  COOL_RESET  = COOL_W'(600);
    localparam logic [COOL_W-1:0]  COOL_MIN    = COOL_W'(30);
    localparam logic [COOL_W-1:0]  COOL_MAX    = COOL_W'(3600);

    typedef struct packed {
        logic [LEVEL_W-1:0] motion_level;
        logic [LEVEL_W-1:0] breathing_level;
    } level_pair_t;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio_pct;
        logic [LEVEL_W-1:0] motion_floor;
        logic [LEVEL_W-1:0] breathing_floor;
        logic [COOL_W-1:0]  hold_ticks;
    } cfg_t;

    // first member sits in the highest bits: motion_alert lands in bit 0
    typedef struct packed {
        logic               warming_up;
        logic [LEVEL_W-1:0] breathing_val;
        logic               breathing_alert;
        logic [LEVEL_W-1:0] motion_val;
        logic               motion_alert;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_CMP
    } back_state_t;

endpackage

### src/rolling_baseline_spike_detector_top.sv
// Top level of the rolling baseline spike detector.
// Depends on rbsd_pkg, rbsd_front, rbsd_queue, rbsd_back (and through it rbsd_ram, rbsd_div).

// Each input transaction carries four signed Doppler bins and a breathing level; each
// produces exactly one result transaction with both levels, the two alert flags and a
// warming-up flag. The front end reduces a transaction to a motion and a breathing level
// in the accepting cycle and pushes it into a four-entry queue, so s_tready only drops
// when that queue is full. The back end takes one queued item at a time through its
// states: ST_IDLE pops it, reads the oldest history entry and forms both baseline means
// from the running history sums by a reciprocal multiplication by the history depth;
// ST_DIV scales the means by the spike ratio; ST_CMP decides both alerts, reloads or
// counts down the cooldowns and swaps the oldest history entry for the new one. ST_CMP
// holds while an earlier result still waits in the output register; the back end only
// pops the next item once ST_CMP has finished the last one. The history rings start out
// as zero without any clearing pass: a fill flag makes unwritten entries read as zero,
// so the block is ready straight after reset. The first PRIME_TICKS results are flagged
// as warming up and never alert. Configuration writes (cfg_valid/cfg_ready, always
// ready) saturate to each register's legal range; indexes beyond the register list are
// dropped. Write configuration only while no transaction is in flight.
module rolling_baseline_spike_detector_top #(
    parameter int HISTORY_DEPTH = 60,
    parameter int PRIME_TICKS   = 60
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input transactions
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // tdata, from bit 0: doppler_bin_a[7:0], doppler_bin_b[15:8], doppler_bin_c[23:16],
    // doppler_bin_d[31:24], breathing_level[38:32], zero pad [39]
    input  logic [rbsd_pkg::S_TDATA_W-1:0]    s_tdata,
    // result transactions
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // tdata, from bit 0: motion_alert[0], motion level[7:1], breathing_alert[8],
    // breathing level[15:9], warming_up[16], zero pad [23:17]
    output logic [rbsd_pkg::M_TDATA_W-1:0]    m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rbsd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rbsd_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import rbsd_pkg::*;

    localparam int PAIR_W = $bits(level_pair_t);

    logic [RATIO_W-1:0] ratio_reg, ratio_next;
    logic [LEVEL_W-1:0] mfloor_reg, mfloor_next;
    logic [LEVEL_W-1:0] bfloor_reg, bfloor_next;
    logic [COOL_W-1:0]  cool_reg, cool_next;
    cfg_t               cfg;

    logic               q_push, q_pop, q_full, q_empty;
    level_pair_t        q_push_data;
    logic [PAIR_W-1:0]  q_pop_raw;
    result_t            result;

    // clamp a written value into [lo, hi]
    function automatic logic [COOL_W-1:0] clamp_val(input logic [COOL_W-1:0] v,
                                                    input logic [COOL_W-1:0] lo,
                                                    input logic [COOL_W-1:0] hi);
        logic [COOL_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign cfg_ready = 1'b1;

    // Register file: take the low bits that each register holds, then saturate.
    always_comb begin
        ratio_next  = ratio_reg;
        mfloor_next = mfloor_reg;
        bfloor_next = bfloor_reg;
        cool_next   = cool_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                REG_RATIO_PCT: begin
                    ratio_next = RATIO_W'(clamp_val(COOL_W'(cfg_data[RATIO_W-1:0]),
                                                    COOL_W'(RATIO_MIN), COOL_W'(RATIO_MAX)));
                end
                REG_MOTION_FLOOR: begin
                    mfloor_next = LEVEL_W'(clamp_val(COOL_W'(cfg_data[LEVEL_W-1:0]),
                                                     COOL_W'(FLOOR_MIN), COOL_W'(FLOOR_MAX)));
                end
                REG_BREATHING_FLOOR: begin
                    bfloor_next = LEVEL_W'(clamp_val(COOL_W'(cfg_data[LEVEL_W-1:0]),
                                                     COOL_W'(FLOOR_MIN), COOL_W'(FLOOR_MAX)));
                end
                REG_HOLD_TICKS: begin
                    cool_next = clamp_val(cfg_data[COOL_W-1:0], COOL_MIN, COOL_MAX);
                end
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg  <= RATIO_RESET;
            mfloor_reg <= MOTION_FLOOR_RESET;
            bfloor_reg <= BREATHING_FLOOR_RESET;
            cool_reg   <= COOL_RESET;
        end else begin
            ratio_reg  <= ratio_next;
            mfloor_reg <= mfloor_next;
            bfloor_reg <= bfloor_next;
            cool_reg   <= cool_next;
        end
    end

    assign cfg.ratio_pct       = ratio_reg;
    assign cfg.motion_floor    = mfloor_reg;
    assign cfg.breathing_floor = bfloor_reg;
    assign cfg.hold_ticks      = cool_reg;

    // Front end: level reduction and accept.
    rbsd_front u_front (
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data)
    );

    // Decouple the two halves so either can stall on its own.
    rbsd_queue #(
        .WIDTH (PAIR_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .pop_data  (q_pop_raw),
        .full      (q_full),
        .empty     (q_empty)
    );

    // Back end: baselines, decisions, history and the result register.
    rbsd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PRIME_TICKS   (PRIME_TICKS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_data   (level_pair_t'(q_pop_raw)),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_result (result)
    );

    assign m_tdata = M_TDATA_W'(result);

    // An alert only fires at or above its channel's floor.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[7:1] >= mfloor_reg))
        else $error("motion alert below motion floor");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[15:9] >= bfloor_reg))
        else $error("breathing alert below breathing floor");

    // Priming results never alert.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[16]) |-> (!m_tdata[0] && !m_tdata[8]))
        else $error("alert raised while warming up");

    // Levels stay on the clamped scale.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[7:1] <= LEVEL_MAX) && (m_tdata[15:9] <= LEVEL_MAX)))
        else $error("level above full scale");
endmodule

### src/rbsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbsd_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 60
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

### src/rbsd_front.sv
// Front end: accepts input transactions and reduces them to a pair of levels.
// Depends on rbsd_pkg.
module rbsd_front (
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [rbsd_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                            q_full,
    output logic                            q_push,
    output rbsd_pkg::level_pair_t           q_push_data
);
    import rbsd_pkg::*;

    logic [BIN_W-1:0]   bin_abs [4];
    logic [BIN_W+1:0]   bin_sum;
    logic [BIN_W-1:0]   motion_raw;
    logic [LEVEL_W-1:0] breathing_raw;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            bin_abs[i] = s_tdata[i*BIN_W + BIN_W-1]
                       ? (~s_tdata[i*BIN_W +: BIN_W] + BIN_W'(1))
                       : s_tdata[i*BIN_W +: BIN_W];
        end
    end

    assign bin_sum = (BIN_W+2)'(bin_abs[0]) + (BIN_W+2)'(bin_abs[1])
                   + (BIN_W+2)'(bin_abs[2]) + (BIN_W+2)'(bin_abs[3]);
    // mean of four: drop two bits
    assign motion_raw    = bin_sum[BIN_W+1:2];
    assign breathing_raw = s_tdata[4*BIN_W +: LEVEL_W];

    // clamp both levels to the top of the scale
    assign q_push_data.motion_level = (motion_raw > BIN_W'(LEVEL_MAX))
                                    ? LEVEL_MAX : motion_raw[LEVEL_W-1:0];
    assign q_push_data.breathing_level = (breathing_raw > LEVEL_MAX)
                                       ? LEVEL_MAX : breathing_raw;

    assign s_tready = ~q_full;
    assign q_push   = s_tvalid & ~q_full;
endmodule

### src/rbsd_queue.sv
// Short FIFO between the front and back ends.
// Depends on rbsd_pkg for the depth.
module rbsd_queue #(
    parameter int WIDTH = 14
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             full,
    output logic             empty
);
    import rbsd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule

### src/rbsd_div.sv
// Division by a constant through a reciprocal multiplication, with the quotient ready in the cycle after start.
// No dependencies.
module rbsd_div #(
    parameter int DIVIDEND_W = 13,
    parameter int DIVISOR    = 60,
    parameter int QUOT_W     = 7
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    output logic                  done,
    output logic [QUOT_W-1:0]     quotient
);
    // rounded-up reciprocal scaled far enough to be exact over every dividend value
    localparam int     SHIFT     = DIVIDEND_W + $clog2(DIVISOR);
    localparam int     RECIP_W   = DIVIDEND_W + 2;
    localparam int     MUL_W     = DIVIDEND_W + RECIP_W;
    localparam longint RECIP_INT = ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1)
                                   / longint'(DIVISOR);
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);

    logic [MUL_W-1:0]  product;
    logic [QUOT_W-1:0] quo_reg, quo_next;
    logic              busy_reg, busy_next;

    assign product   = MUL_W'(dividend) * MUL_W'(RECIP);
    assign quo_next  = start ? QUOT_W'(product >> SHIFT) : quo_reg;
    assign busy_next = start;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
    end

    assign done     = busy_reg;
    assign quotient = quo_reg;
endmodule

### src/rbsd_back.sv
// Back end: baseline means, spike decisions, cooldowns, history update, result register.
// Depends on rbsd_pkg, rbsd_ram and rbsd_div.
module rbsd_back #(
    parameter int HISTORY_DEPTH = 60,
    parameter int PRIME_TICKS   = 60
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rbsd_pkg::cfg_t         cfg,
    input  logic                   q_empty,
    input  rbsd_pkg::level_pair_t  q_data,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output rbsd_pkg::result_t      m_result
);
    import rbsd_pkg::*;

    localparam int POS_W  = $clog2(HISTORY_DEPTH);
    localparam int SUM_W  = $clog2(LEVEL_MAX_INT * HISTORY_DEPTH + 1);
    localparam int WARM_W = $clog2(PRIME_TICKS + 1);
    localparam int PAIR_W = $bits(level_pair_t);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HISTORY_DEPTH - 1);

    back_state_t        state_reg, state_next;
    level_pair_t        item_reg, item_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               full_reg, full_next;
    logic [WARM_W-1:0]  warm_reg, warm_next;
    logic [COOL_W-1:0]  mcool_reg, mcool_next;
    logic [COOL_W-1:0]  bcool_reg, bcool_next;
    logic [SUM_W-1:0]   msum_reg, msum_next;
    logic [SUM_W-1:0]   bsum_reg, bsum_next;
    logic [PROD_W-1:0]  mprod_reg, mprod_next;
    logic [PROD_W-1:0]  bprod_reg, bprod_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_reg, out_next;

    logic               ram_rd_en, ram_wr_en;
    logic [PAIR_W-1:0]  ram_rd_data;
    level_pair_t        old_pair;
    logic               div_start, mdiv_done, bdiv_done;
    logic [LEVEL_W-1:0] m_avg, b_avg;

    logic [COOL_W-1:0]   mcool_dec, bcool_dec;
    logic [LVL100_W-1:0] m_lvl100, b_lvl100;
    logic                priming, m_fire, b_fire, out_free;

    rbsd_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (pos_reg),
        .wr_data (item_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (pos_reg),
        .rd_data (ram_rd_data)
    );

    rbsd_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR    (HISTORY_DEPTH),
        .QUOT_W     (LEVEL_W)
    ) u_mdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (msum_reg),
        .done     (mdiv_done),
        .quotient (m_avg)
    );

    rbsd_div #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR    (HISTORY_DEPTH),
        .QUOT_W     (LEVEL_W)
    ) u_bdiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (bsum_reg),
        .done     (bdiv_done),
        .quotient (b_avg)
    );

    // an entry not yet written since reset reads as zero
    assign old_pair  = full_reg ? level_pair_t'(ram_rd_data) : '0;
    assign mcool_dec = (mcool_reg != '0) ? mcool_reg - COOL_W'(1) : mcool_reg;
    assign bcool_dec = (bcool_reg != '0) ? bcool_reg - COOL_W'(1) : bcool_reg;
    assign m_lvl100  = LVL100_W'(item_reg.motion_level) * PERCENT;
    assign b_lvl100  = LVL100_W'(item_reg.breathing_level) * PERCENT;
    assign priming   = (warm_reg != '0);
    assign out_free  = ~out_valid_reg | m_tready;

    assign m_fire = ~priming && (mcool_dec == '0)
                 && (item_reg.motion_level >= cfg.motion_floor)
                 && (PROD_W'(m_lvl100) >= mprod_reg);
    assign b_fire = ~priming && (bcool_dec == '0)
                 && (item_reg.breathing_level >= cfg.breathing_floor)
                 && (PROD_W'(b_lvl100) >= bprod_reg);

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        pos_next       = pos_reg;
        full_next      = full_reg;
        warm_next      = warm_reg;
        mcool_next     = mcool_reg;
        bcool_next     = bcool_reg;
        msum_next      = msum_reg;
        bsum_next      = bsum_reg;
        mprod_next     = mprod_reg;
        bprod_next     = bprod_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        q_pop          = 1'b0;
        ram_rd_en      = 1'b0;
        ram_wr_en      = 1'b0;
        div_start      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    item_next  = q_data;
                    ram_rd_en  = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (mdiv_done && bdiv_done) begin
                    mprod_next = PROD_W'(m_avg) * PROD_W'(cfg.ratio_pct);
                    bprod_next = PROD_W'(b_avg) * PROD_W'(cfg.ratio_pct);
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (out_free) begin
                    mcool_next = m_fire ? cfg.hold_ticks : mcool_dec;
                    bcool_next = b_fire ? cfg.hold_ticks : bcool_dec;
                    warm_next  = priming ? warm_reg - WARM_W'(1) : warm_reg;
                    // swap the oldest entry for the current one in both sums
                    msum_next  = msum_reg - SUM_W'(old_pair.motion_level)
                               + SUM_W'(item_reg.motion_level);
                    bsum_next  = bsum_reg - SUM_W'(old_pair.breathing_level)
                               + SUM_W'(item_reg.breathing_level);
                    ram_wr_en  = 1'b1;
                    pos_next   = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);
                    full_next  = full_reg | (pos_reg == POS_LAST);
                    out_next.motion_alert    = m_fire;
                    out_next.motion_val      = item_reg.motion_level;
                    out_next.breathing_alert = b_fire;
                    out_next.breathing_val   = item_reg.breathing_level;
                    out_next.warming_up      = priming;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            pos_reg       <= '0;
            full_reg      <= 1'b0;
            warm_reg      <= WARM_W'(PRIME_TICKS);
            mcool_reg     <= '0;
            bcool_reg     <= '0;
            msum_reg      <= '0;
            bsum_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            full_reg      <= full_next;
            warm_reg      <= warm_next;
            mcool_reg     <= mcool_next;
            bcool_reg     <= bcool_next;
            msum_reg      <= msum_next;
            bsum_reg      <= bsum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        mprod_reg <= mprod_next;
        bprod_reg <= bprod_next;
        out_reg   <= out_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_result = out_reg;
endmodule

### tb/sv/tb.sv
// Self-checking testbench for rolling_baseline_spike_detector_top.
// Holds its own model of the baseline rings, priming and cooldowns in a small
// scoreboard class and drives the stream and register ports; needs rbsd_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rbsd_pkg::*;

    localparam int HISTORY_DEPTH = 60;
    localparam int PRIME_TICKS   = 60;
    localparam int PHASES        = 6;
    localparam int PHASE_TICKS   = 145;
    localparam int SETTLE_CYCLES = 48;

    typedef enum int {
        STYLE_QUIET,
        STYLE_SPIKE,
        STYLE_NOISE
    } tick_style_t;

    // Predicts one result per tick and checks the results in order.
    class spike_scoreboard;
        logic [LEVEL_W-1:0] motion_ring [HISTORY_DEPTH];
        logic [LEVEL_W-1:0] breath_ring [HISTORY_DEPTH];
        int unsigned ring_pos;
        int unsigned prime_left;
        int unsigned motion_hold;
        int unsigned breath_hold;
        int unsigned ratio_pct;
        int unsigned motion_min;
        int unsigned breath_min;
        int unsigned hold_reload;
        result_t     awaited_q [$];
        int unsigned errors;
        int unsigned ticks;
        int unsigned primed;
        int unsigned motion_alerts;
        int unsigned breath_alerts;

        function new();
            foreach (motion_ring[i]) begin
                motion_ring[i] = '0;
                breath_ring[i] = '0;
            end
            ring_pos      = 0;
            prime_left    = PRIME_TICKS;
            motion_hold   = 0;
            breath_hold   = 0;
            ratio_pct     = 32'(RATIO_RESET);
            motion_min    = 32'(MOTION_FLOOR_RESET);
            breath_min    = 32'(BREATHING_FLOOR_RESET);
            hold_reload   = 32'(COOL_RESET);
            errors        = 0;
            ticks         = 0;
            primed        = 0;
            motion_alerts = 0;
            breath_alerts = 0;
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function int unsigned pending();
            return awaited_q.size();
        endfunction

        // Only the register's own width counts; the rest of the write data is dropped.
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_RATIO_PCT:       ratio_pct   = clamp(32'(data[RATIO_W-1:0]),
                                                         32'(RATIO_MIN), 32'(RATIO_MAX));
                REG_MOTION_FLOOR:    motion_min  = clamp(32'(data[LEVEL_W-1:0]),
                                                         32'(FLOOR_MIN), 32'(FLOOR_MAX));
                REG_BREATHING_FLOOR: breath_min  = clamp(32'(data[LEVEL_W-1:0]),
                                                         32'(FLOOR_MIN), 32'(FLOOR_MAX));
                REG_HOLD_TICKS:      hold_reload = clamp(32'(data[COOL_W-1:0]),
                                                         32'(COOL_MIN), 32'(COOL_MAX));
                default: ;
            endcase
        endfunction

        function void note_tick(logic [S_TDATA_W-1:0] word);
            int unsigned mag_sum;
            int unsigned motion;
            int unsigned breath;
            int unsigned motion_sum;
            int unsigned breath_sum;
            int v;
            logic signed [BIN_W-1:0] bin;
            result_t want;
            mag_sum = 0;
            for (int k = 0; k < 4; k++) begin
                bin = word[k*BIN_W +: BIN_W];
                v = int'(bin);
                mag_sum += (v < 0) ? -v : v;
            end
            motion = clamp(mag_sum / 4, 0, LEVEL_MAX_INT);
            breath = clamp(32'(word[4*BIN_W +: LEVEL_W]), 0, LEVEL_MAX_INT);

            if (motion_hold > 0) motion_hold--;
            if (breath_hold > 0) breath_hold--;

            want = '0;
            want.motion_val    = LEVEL_W'(motion);
            want.breathing_val = LEVEL_W'(breath);
            if (prime_left > 0) begin
                want.warming_up = 1'b1;
                prime_left--;
                primed++;
            end else begin
                motion_sum = 0;
                breath_sum = 0;
                foreach (motion_ring[i]) begin
                    motion_sum += 32'(motion_ring[i]);
                    breath_sum += 32'(breath_ring[i]);
                end
                // compare against the floored mean of the ring before this tick joins it
                if (motion_hold == 0 && motion >= motion_min &&
                    motion * 100 >= (motion_sum / HISTORY_DEPTH) * ratio_pct) begin
                    want.motion_alert = 1'b1;
                    motion_hold = hold_reload;
                    motion_alerts++;
                end
                if (breath_hold == 0 && breath >= breath_min &&
                    breath * 100 >= (breath_sum / HISTORY_DEPTH) * ratio_pct) begin
                    want.breathing_alert = 1'b1;
                    breath_hold = hold_reload;
                    breath_alerts++;
                end
            end

            motion_ring[ring_pos] = LEVEL_W'(motion);
            breath_ring[ring_pos] = LEVEL_W'(breath);
            ring_pos = (ring_pos + 1) % HISTORY_DEPTH;
            ticks++;
            awaited_q.push_back(want);
        endfunction

        function void compare_field(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] word);
            result_t got;
            result_t want;
            got = word[$bits(result_t)-1:0];
            if (awaited_q.size() == 0) begin
                $error("result 0x%h arrived with no tick outstanding", word);
                errors++;
                return;
            end
            want = awaited_q.pop_front();
            compare_field("motion_alert", 8'(want.motion_alert), 8'(got.motion_alert));
            compare_field("motion_val", 8'(want.motion_val), 8'(got.motion_val));
            compare_field("breathing_alert", 8'(want.breathing_alert), 8'(got.breathing_alert));
            compare_field("breathing_val", 8'(want.breathing_val), 8'(got.breathing_val));
            compare_field("warming_up", 8'(want.warming_up), 8'(got.warming_up));
            compare_field("pad", 8'd0, 8'(word[M_TDATA_W-1:$bits(result_t)]));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    calm = 1'b0;
    int unsigned           settings_seen = 1;

    spike_scoreboard tracker = new();

    rolling_baseline_spike_detector_top #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PRIME_TICKS   (PRIME_TICKS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic logic [S_TDATA_W-1:0] pack_tick(int a, int b, int c, int d, int breath);
        return {1'b0, LEVEL_W'(breath), BIN_W'(d), BIN_W'(c), BIN_W'(b), BIN_W'(a)};
    endfunction

    function automatic tick_style_t pick_style();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70) return STYLE_QUIET;
        if (r < 85) return STYLE_SPIKE;
        return STYLE_NOISE;
    endfunction

    // Quiet stretches build a low baseline, spikes rise well above it, noise covers every bit.
    function automatic logic [S_TDATA_W-1:0] make_tick(tick_style_t style);
        logic [S_TDATA_W-1:0] word;
        logic [BIN_W-1:0]     bin;
        int unsigned          mag;
        word = '0;
        for (int k = 0; k < 4; k++) begin
            mag = (style == STYLE_SPIKE) ? $urandom_range(60, 128) : $urandom_range(0, 12);
            if (style == STYLE_NOISE) bin = BIN_W'($urandom);
            else bin = $urandom_range(0, 1) ? BIN_W'(-int'(mag)) : BIN_W'(mag);
            word[k*BIN_W +: BIN_W] = bin;
        end
        case (style)
            STYLE_QUIET: word[4*BIN_W +: LEVEL_W] = LEVEL_W'($urandom_range(0, 20));
            STYLE_SPIKE: word[4*BIN_W +: LEVEL_W] = LEVEL_W'($urandom_range(40, 127));
            default:     word[4*BIN_W +: LEVEL_W] = LEVEL_W'($urandom_range(0, 127));
        endcase
        return word;
    endfunction

    // Entered at a falling edge; leaves s_tvalid high at the falling edge after the tick is accepted.
    task automatic send_tick(input logic [S_TDATA_W-1:0] word);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        tracker.note_tick(word);
        @(negedge aclk);
    endtask

    task automatic pause_sender(int unsigned cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Hold the sender until every outstanding result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (tracker.pending() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, data);
        @(negedge aclk);
    endtask

    // Saturation both ways, masked upper bits and a dropped index are all exercised here.
    task automatic apply_setting(int phase);
        logic [CFG_DATA_W-1:0] raw [4];
        case (phase)
            1: raw = '{16'd0, 16'd0, 16'd1, 16'd5};
            2: raw = '{16'hfc00 | 16'd200, 16'hff80 | 16'd40, 16'h0f80 | 16'd25, 16'hf064};
            PHASES - 1: raw = '{16'hffff, 16'd127, 16'd100, 16'd4095};
            default: begin
                raw[0] = CFG_DATA_W'($urandom_range(100, 700));
                raw[1] = CFG_DATA_W'($urandom_range(0, 90));
                raw[2] = CFG_DATA_W'($urandom_range(0, 90));
                raw[3] = CFG_DATA_W'($urandom_range(0, 150));
            end
        endcase
        write_reg(REG_RATIO_PCT, raw[0]);
        write_reg(CFG_IDX_W'($urandom_range(32'(REG_HOLD_TICKS) + 1, 255)),
                  CFG_DATA_W'($urandom));
        write_reg(REG_MOTION_FLOOR, raw[1]);
        write_reg(REG_BREATHING_FLOOR, raw[2]);
        write_reg(REG_HOLD_TICKS, raw[3]);
        cfg_valid <= 1'b0;
        @(negedge aclk);
        settings_seen++;
    endtask

    // Extremes of every field, breathing saturation, truncation of the motion mean.
    logic [S_TDATA_W-1:0] priming_ticks [12];
    initial begin
        priming_ticks[0]  = pack_tick(0, 0, 0, 0, 0);
        priming_ticks[1]  = pack_tick(-128, -128, -128, -128, 100);
        priming_ticks[2]  = pack_tick(127, 127, 127, 127, 101);
        priming_ticks[3]  = pack_tick(-1, -1, -1, -1, 127);
        priming_ticks[4]  = pack_tick(127, -128, 0, 1, 64);
        priming_ticks[5]  = pack_tick(100, -100, 100, -100, 99);
        priming_ticks[6]  = pack_tick(101, 100, 100, 100, 1);
        priming_ticks[7]  = pack_tick(1, 1, 1, 0, 50);
        priming_ticks[8]  = pack_tick(-3, 2, 0, 0, 49);
        priming_ticks[9]  = pack_tick(85, -86, 85, -86, 85);
        priming_ticks[10] = pack_tick(-127, 0, 0, 0, 126);
        priming_ticks[11] = pack_tick(4, -4, 4, -4, 0);
    end

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: prime the rings, then probe both floors from just below.
        // No alert may fire here, since the reset cooldown would silence a channel
        // for most of the run.
        foreach (priming_ticks[i]) send_tick(priming_ticks[i]);
        for (int n = 0; n < PRIME_TICKS - 12; n++) begin
            send_tick(make_tick(pick_style()));
            if ($urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 8));
        end
        send_tick(pack_tick(59, -59, 59, -59, 49));
        send_tick(pack_tick(-60, 59, -59, 59, 20));
        for (int n = 0; n < 20; n++) send_tick(make_tick(STYLE_QUIET));

        for (int phase = 1; phase < PHASES; phase++) begin
            drain();
            apply_setting(phase);
            calm = (phase == PHASES - 1);
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (n == PHASE_TICKS / 2) drain();
                send_tick(make_tick(pick_style()));
                if (!calm && $urandom_range(0, 3) == 0) pause_sender($urandom_range(1, 8));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        $display("Sent %0d ticks (%0d priming) under %0d register settings.",
                 tracker.ticks, tracker.primed, settings_seen);
        $display("Predicted %0d motion and %0d breathing alerts; %0d mismatches.",
                 tracker.motion_alerts, tracker.breath_alerts, tracker.errors);
        if (tracker.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Receiver back-pressure in random bursts; none once the run turns calm.
    initial begin
        m_tready = 1'b0;
        @(posedge aresetn);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) tracker.check_result(m_tdata);
    end

    initial begin
        #400000;
        $display("Timed out with %0d results outstanding.", tracker.pending());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### rolling_baseline_spike_detector_top.f
src/rbsd_pkg.sv
src/rbsd_ram.sv
src/rbsd_front.sv
src/rbsd_queue.sv
src/rbsd_div.sv
src/rbsd_back.sv
src/rolling_baseline_spike_detector_top.sv
tb/sv/tb.sv
